// File: hw/rtl/ppt_pkg.sv
`default_nettype none
package ppt_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_RADIUS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_LIMIT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_SPACING = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COUNT    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_SPEED     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_SPEED     = 4'd7;

  localparam logic [1:0] FUNC_WAYPOINT = 2'd0;
  localparam logic [1:0] FUNC_END      = 2'd1;
  localparam logic [1:0] FUNC_POSE     = 2'd2;

  localparam logic [20:0] LOOKAHEAD_RST     = 21'd58982;
  localparam logic [20:0] GOAL_RADIUS_RST   = 21'd32768;
  localparam logic [16:0] STEER_LIMIT_RST   = 17'd27453;
  localparam logic [20:0] POINT_SPACING_RST = 21'd32768;
  localparam logic [7:0]  HOLD_COUNT_RST    = 8'd40;
  localparam logic [21:0] SLOW_SPEED_RST    = 22'd131072;
  localparam logic [21:0] MID_SPEED_RST     = 22'd196608;
  localparam logic [21:0] TOP_SPEED_RST     = 22'd327680;

  localparam logic signed [63:0] NEAR_GOAL = 64'sd163840;
  localparam logic signed [63:0] STEER_MID = 64'sd9830;
  localparam logic [63:0]        REL_LIMIT = 64'd1 << 26;
  localparam logic signed [63:0] RND14     = 64'sd8192;

  typedef struct packed {
    logic [20:0] lookahead;
    logic [20:0] goal_radius;
    logic [16:0] steer_limit;
    logic [20:0] point_spacing;
    logic [7:0]  hold_count;
    logic [21:0] slow_speed;
    logic [21:0] mid_speed;
    logic [21:0] top_speed;
  } cfg_t;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_SQRT} alu_op_t;

  typedef enum logic [1:0] {ALU_IDLE, ALU_MUL, ALU_DIV, ALU_SQRT} alu_state_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] y;
  } alu_rsp_t;

  typedef enum logic [5:0] {
    S_IDLE, S_WAIT, S_MAG0, S_MAG1, S_MAG2, S_MAG3,
    S_W_LOOP, S_W_RD, S_W_DIST, S_W_MX, S_W_DX, S_W_MY, S_W_DY,
    S_P_SEG, S_P_RD0, S_P_RD1, S_P_A1, S_P_A2, S_P_LEN,
    S_P_AL1, S_P_AL2, S_P_AL3, S_P_CR1, S_P_CR2, S_P_CR3,
    S_P_H1, S_P_H2, S_P_HALF, S_P_U, S_P_TX1, S_P_TX2, S_P_TY1, S_P_TY2,
    S_N_RD0, S_N_MAG0, S_N_BEST, S_N_RD, S_N_MAG, S_N_CMP, S_N_TGT_RD, S_N_TGT,
    S_G_DIST, S_G_CHK, S_G_X1, S_G_X2, S_G_Y1, S_G_Y2, S_G_D, S_G_R, S_G_ST, S_G_S,
    S_OUT
  } seq_state_t;

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sx32(logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic signed [63:0] sx16(logic signed [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // shift that brings both magnitude components below 2^31
  function automatic logic [5:0] mag_shift(logic [63:0] v);
    logic [5:0] s;
    s = '0;
    for (int k = 31; k < 64; k++) begin
      if (v[k]) s = 6'(k - 30);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ppt_alu.sv
`default_nettype none
module ppt_alu import ppt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  alu_state_t  state_r, state_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] rem;
  logic [63:0] trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ALU_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    rem       = {acc_r[62:0], x_r[63]};
    trial     = acc_r + y_r;
    case (state_r)
      ALU_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_MUL: begin
              acc_nxt   = '0;
              x_nxt     = req.a;
              y_nxt     = req.b;
              state_nxt = ALU_MUL;
            end
            OP_DIV: begin
              // round half away from zero: bias the magnitude by half the divisor
              acc_nxt   = '0;
              x_nxt     = abs64(req.a) + (req.b >> 1);
              y_nxt     = req.b;
              neg_nxt   = req.a[63];
              cnt_nxt   = 7'd64;
              state_nxt = ALU_DIV;
            end
            OP_SQRT: begin
              acc_nxt   = '0;
              x_nxt     = req.a;
              y_nxt     = 64'd1 << 62;
              cnt_nxt   = 7'd32;
              state_nxt = ALU_SQRT;
            end
            default: state_nxt = ALU_IDLE;
          endcase
        end
      end
      ALU_MUL: begin
        if (y_r == '0) begin
          res_nxt   = acc_r;
          done_nxt  = 1'b1;
          state_nxt = ALU_IDLE;
        end else begin
          if (y_r[0]) acc_nxt = acc_r + x_r;
          x_nxt = {x_r[62:0], 1'b0};
          y_nxt = {1'b0, y_r[63:1]};
        end
      end
      ALU_DIV: begin
        if (cnt_r == '0) begin
          res_nxt   = neg_r ? 64'(-x_r) : x_r;
          done_nxt  = 1'b1;
          state_nxt = ALU_IDLE;
        end else begin
          if (rem >= y_r) begin
            acc_nxt = rem - y_r;
            x_nxt   = {x_r[62:0], 1'b1};
          end else begin
            acc_nxt = rem;
            x_nxt   = {x_r[62:0], 1'b0};
          end
          cnt_nxt = cnt_r - 7'd1;
        end
      end
      ALU_SQRT: begin
        if (cnt_r == '0) begin
          res_nxt   = acc_r;
          done_nxt  = 1'b1;
          state_nxt = ALU_IDLE;
        end else begin
          if (x_r >= trial) begin
            x_nxt   = x_r - trial;
            acc_nxt = (acc_r >> 1) + y_r;
          end else begin
            acc_nxt = acc_r >> 1;
          end
          y_nxt   = y_r >> 2;
          cnt_nxt = cnt_r - 7'd1;
        end
      end
      default: state_nxt = ALU_IDLE;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.y    = res_r;

endmodule
`default_nettype wire

// File: hw/rtl/ppt_seq.sv
`default_nettype none
module ppt_seq import ppt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [15:0] in_heading_cos,
  input  wire logic signed [15:0] in_heading_sin,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [17:0]      out_steering,
  output logic [21:0]             out_speed,
  output logic                    out_goal_reached,
  output logic                    out_held,
  output logic                    out_used_nearest,
  output alu_req_t                alu_req,
  input  wire alu_rsp_t           alu_rsp
);

  logic [63:0] mem [MAX_POINTS];
  logic [63:0] rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [63:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  seq_state_t state_r, state_nxt;
  seq_state_t ret_r, ret_nxt;
  seq_state_t mag_ret_r, mag_ret_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] track_r, track_nxt;
  logic              armed_r, armed_nxt;
  logic              fresh_r, fresh_nxt;
  logic signed [31:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic signed [31:0] goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  logic [7:0]         hold_cnt_r, hold_cnt_nxt;
  logic signed [17:0] held_steer_r, held_steer_nxt;
  logic [21:0]        held_speed_r, held_speed_nxt;

  logic signed [31:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [15:0] hc_r, hc_nxt, hs_r, hs_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic signed [31:0] bx_r, bx_nxt, by_r, by_nxt;
  logic signed [63:0] dx_r, dx_nxt, dy_r, dy_nxt, fx_r, fx_nxt, fy_r, fy_nxt;
  logic signed [63:0] d_r, d_nxt, t_r, t_nxt, len_r, len_nxt;
  logic signed [63:0] along_r, along_nxt, cr_r, cr_nxt;
  logic signed [63:0] u0_r, u0_nxt, u1_r, u1_nxt, u_r, u_nxt;
  logic signed [63:0] tx_r, tx_nxt, ty_r, ty_nxt, bd_r, bd_nxt;
  logic [ADDR_W-1:0]  best_r, best_nxt;
  logic               hit_r, hit_nxt;
  logic signed [63:0] gd_r, gd_nxt, xc_r, xc_nxt, yc_r, yc_nxt;
  logic signed [63:0] mx_r, mx_nxt, my_r, my_nxt, sq_r, sq_nxt, mag_r, mag_nxt;
  logic [63:0]        py2_r, py2_nxt;
  logic [5:0]         s_r, s_nxt;

  logic signed [17:0] res_steer_r, res_steer_nxt;
  logic [21:0]        res_speed_r, res_speed_nxt;
  logic               res_goal_r, res_goal_nxt;
  logic               res_held_r, res_held_nxt;
  logic               res_near_r, res_near_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [17:0] out_steer_r, out_steer_nxt;
  logic [21:0]        out_speed_r, out_speed_nxt;
  logic               out_goal_r, out_goal_nxt;
  logic               out_held_r, out_held_nxt;
  logic               out_near_r, out_near_nxt;

  logic signed [31:0] rd_x, rd_y;
  logic signed [63:0] alu_y, sp, lim, lk;
  logic [63:0]        ax, ay, pxs;
  logic [5:0]         sh;
  logic signed [63:0] gx, gy, sum, steer;
  logic               far;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      track_r      <= '0;
      armed_r      <= 1'b0;
      fresh_r      <= 1'b1;
      last_x_r     <= '0;
      last_y_r     <= '0;
      goal_x_r     <= '0;
      goal_y_r     <= '0;
      hold_cnt_r   <= HOLD_COUNT_RST;
      held_steer_r <= '0;
      held_speed_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      track_r      <= track_nxt;
      armed_r      <= armed_nxt;
      fresh_r      <= fresh_nxt;
      last_x_r     <= last_x_nxt;
      last_y_r     <= last_y_nxt;
      goal_x_r     <= goal_x_nxt;
      goal_y_r     <= goal_y_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      held_steer_r <= held_steer_nxt;
      held_speed_r <= held_speed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ret_r       <= ret_nxt;
    mag_ret_r   <= mag_ret_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    hc_r        <= hc_nxt;
    hs_r        <= hs_nxt;
    idx_r       <= idx_nxt;
    bx_r        <= bx_nxt;
    by_r        <= by_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    fx_r        <= fx_nxt;
    fy_r        <= fy_nxt;
    d_r         <= d_nxt;
    t_r         <= t_nxt;
    len_r       <= len_nxt;
    along_r     <= along_nxt;
    cr_r        <= cr_nxt;
    u0_r        <= u0_nxt;
    u1_r        <= u1_nxt;
    u_r         <= u_nxt;
    tx_r        <= tx_nxt;
    ty_r        <= ty_nxt;
    bd_r        <= bd_nxt;
    best_r      <= best_nxt;
    hit_r       <= hit_nxt;
    gd_r        <= gd_nxt;
    xc_r        <= xc_nxt;
    yc_r        <= yc_nxt;
    mx_r        <= mx_nxt;
    my_r        <= my_nxt;
    sq_r        <= sq_nxt;
    mag_r       <= mag_nxt;
    py2_r       <= py2_nxt;
    s_r         <= s_nxt;
    res_steer_r <= res_steer_nxt;
    res_speed_r <= res_speed_nxt;
    res_goal_r  <= res_goal_nxt;
    res_held_r  <= res_held_nxt;
    res_near_r  <= res_near_nxt;
    out_steer_r <= out_steer_nxt;
    out_speed_r <= out_speed_nxt;
    out_goal_r  <= out_goal_nxt;
    out_held_r  <= out_held_nxt;
    out_near_r  <= out_near_nxt;
  end

  always_comb begin
    rd_x  = $signed(rd_data_r[63:32]);
    rd_y  = $signed(rd_data_r[31:0]);
    alu_y = $signed(alu_rsp.y);
    sp    = (cfg.point_spacing == '0) ? 64'sd1 : $signed({43'd0, cfg.point_spacing});
    lim   = $signed({47'd0, cfg.steer_limit});
    lk    = $signed({43'd0, cfg.lookahead});
    ax    = abs64(mx_r);
    ay    = abs64(my_r);
    sh    = mag_shift(ax | ay);
    pxs   = ax >> sh;
    gx    = sx32(rd_x) - sx32(px_r);
    gy    = sx32(rd_y) - sx32(py_r);
    far   = (abs64(fx_r) >= REL_LIMIT) || (abs64(fy_r) >= REL_LIMIT) ||
            (abs64(gx) >= REL_LIMIT) || (abs64(gy) >= REL_LIMIT);
    sum   = '0;
    steer = t_r;

    state_nxt      = state_r;
    ret_nxt        = ret_r;
    mag_ret_nxt    = mag_ret_r;
    count_nxt      = count_r;
    track_nxt      = track_r;
    armed_nxt      = armed_r;
    fresh_nxt      = fresh_r;
    last_x_nxt     = last_x_r;
    last_y_nxt     = last_y_r;
    goal_x_nxt     = goal_x_r;
    goal_y_nxt     = goal_y_r;
    hold_cnt_nxt   = hold_cnt_r;
    held_steer_nxt = held_steer_r;
    held_speed_nxt = held_speed_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    hc_nxt         = hc_r;
    hs_nxt         = hs_r;
    idx_nxt        = idx_r;
    bx_nxt         = bx_r;
    by_nxt         = by_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    fx_nxt         = fx_r;
    fy_nxt         = fy_r;
    d_nxt          = d_r;
    t_nxt          = t_r;
    len_nxt        = len_r;
    along_nxt      = along_r;
    cr_nxt         = cr_r;
    u0_nxt         = u0_r;
    u1_nxt         = u1_r;
    u_nxt          = u_r;
    tx_nxt         = tx_r;
    ty_nxt         = ty_r;
    bd_nxt         = bd_r;
    best_nxt       = best_r;
    hit_nxt        = hit_r;
    gd_nxt         = gd_r;
    xc_nxt         = xc_r;
    yc_nxt         = yc_r;
    mx_nxt         = mx_r;
    my_nxt         = my_r;
    sq_nxt         = sq_r;
    mag_nxt        = mag_r;
    py2_nxt        = py2_r;
    s_nxt          = s_r;
    res_steer_nxt  = res_steer_r;
    res_speed_nxt  = res_speed_r;
    res_goal_nxt   = res_goal_r;
    res_held_nxt   = res_held_r;
    res_near_nxt   = res_near_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_steer_nxt  = out_steer_r;
    out_speed_nxt  = out_speed_r;
    out_goal_nxt   = out_goal_r;
    out_held_nxt   = out_held_r;
    out_near_nxt   = out_near_r;

    mem_we    = 1'b0;
    mem_waddr = count_r[ADDR_W-1:0];
    mem_wdata = {last_x_r, last_y_r};
    mem_raddr = idx_r[ADDR_W-1:0];

    alu_req.start = 1'b0;
    alu_req.op    = OP_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          px_nxt = in_pos_x;
          py_nxt = in_pos_y;
          hc_nxt = in_heading_cos;
          hs_nxt = in_heading_sin;
          case (in_func)
            FUNC_WAYPOINT: begin
              last_x_nxt = in_pos_x;
              last_y_nxt = in_pos_y;
              if (fresh_r) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {in_pos_x, in_pos_y};
                count_nxt = CNT_W'(1);
                track_nxt = '0;
                armed_nxt = 1'b0;
                fresh_nxt = 1'b0;
              end else begin
                state_nxt = S_W_LOOP;
              end
            end
            FUNC_END: begin
              if (!fresh_r) begin
                mem_we     = 1'b1;
                count_nxt  = count_r + 1'b1;
                goal_x_nxt = last_x_r;
                goal_y_nxt = last_y_r;
                armed_nxt  = 1'b1;
                track_nxt  = '0;
                fresh_nxt  = 1'b1;
              end
            end
            FUNC_POSE: begin
              if (armed_r) begin
                if (hold_cnt_r < cfg.hold_count) begin
                  hold_cnt_nxt  = hold_cnt_r + 8'd1;
                  res_steer_nxt = held_steer_r;
                  res_speed_nxt = held_speed_r;
                  res_goal_nxt  = 1'b0;
                  res_held_nxt  = 1'b1;
                  res_near_nxt  = 1'b0;
                  state_nxt     = S_OUT;
                end else begin
                  hold_cnt_nxt = '0;
                  idx_nxt      = {1'b0, track_r};
                  hit_nxt      = 1'b0;
                  state_nxt    = S_P_SEG;
                end
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_WAIT: begin
        if (alu_rsp.done) state_nxt = ret_r;
      end

      // magnitude of (mx, my) with prescale so the squares fit
      S_MAG0: begin
        py2_nxt       = ay >> sh;
        s_nxt         = sh;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = pxs;
        alu_req.b     = pxs;
        ret_nxt       = S_MAG1;
        state_nxt     = S_WAIT;
      end
      S_MAG1: begin
        sq_nxt        = alu_y;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = py2_r;
        alu_req.b     = py2_r;
        ret_nxt       = S_MAG2;
        state_nxt     = S_WAIT;
      end
      S_MAG2: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_SQRT;
        alu_req.a     = 64'(sq_r + alu_y);
        ret_nxt       = S_MAG3;
        state_nxt     = S_WAIT;
      end
      S_MAG3: begin
        mag_nxt   = alu_y <<< s_r;
        state_nxt = mag_ret_r;
      end

      // densify toward the new waypoint
      S_W_LOOP: begin
        if (count_r >= CNT_W'(MAX_POINTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          mem_raddr = ADDR_W'(count_r - 1'b1);
          state_nxt = S_W_RD;
        end
      end
      S_W_RD: begin
        bx_nxt      = rd_x;
        by_nxt      = rd_y;
        dx_nxt      = sx32(px_r) - sx32(rd_x);
        dy_nxt      = sx32(py_r) - sx32(rd_y);
        mx_nxt      = sx32(px_r) - sx32(rd_x);
        my_nxt      = sx32(py_r) - sx32(rd_y);
        mag_ret_nxt = S_W_DIST;
        state_nxt   = S_MAG0;
      end
      S_W_DIST: begin
        d_nxt = mag_r;
        if (mag_r <= sp) begin
          state_nxt = S_IDLE;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_MUL;
          alu_req.a     = dx_r;
          alu_req.b     = sp;
          ret_nxt       = S_W_MX;
          state_nxt     = S_WAIT;
        end
      end
      S_W_MX: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.a     = alu_y;
        alu_req.b     = d_r;
        ret_nxt       = S_W_DX;
        state_nxt     = S_WAIT;
      end
      S_W_DX: begin
        t_nxt         = sx32(bx_r) + alu_y;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = dy_r;
        alu_req.b     = sp;
        ret_nxt       = S_W_MY;
        state_nxt     = S_WAIT;
      end
      S_W_MY: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.a     = alu_y;
        alu_req.b     = d_r;
        ret_nxt       = S_W_DY;
        state_nxt     = S_WAIT;
      end
      S_W_DY: begin
        sum       = sx32(by_r) + alu_y;
        mem_we    = 1'b1;
        mem_wdata = {t_r[31:0], sum[31:0]};
        count_nxt = count_r + 1'b1;
        state_nxt = S_W_LOOP;
      end

      // lookahead search, one segment per pass
      S_P_SEG: begin
        if ((idx_r + 1'b1) >= count_r) begin
          state_nxt = S_N_RD0;
        end else begin
          mem_raddr = idx_r[ADDR_W-1:0];
          state_nxt = S_P_RD0;
        end
      end
      S_P_RD0: begin
        fx_nxt    = sx32(rd_x) - sx32(px_r);
        fy_nxt    = sx32(rd_y) - sx32(py_r);
        mem_raddr = ADDR_W'(idx_r + 1'b1);
        state_nxt = S_P_RD1;
      end
      S_P_RD1: begin
        if (far) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_P_SEG;
        end else begin
          dx_nxt        = gx - fx_r;
          dy_nxt        = gy - fy_r;
          alu_req.start = 1'b1;
          alu_req.op    = OP_MUL;
          alu_req.a     = gx - fx_r;
          alu_req.b     = gx - fx_r;
          ret_nxt       = S_P_A1;
          state_nxt     = S_WAIT;
        end
      end
      S_P_A1: begin
        t_nxt         = alu_y;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = dy_r;
        alu_req.b     = dy_r;
        ret_nxt       = S_P_A2;
        state_nxt     = S_WAIT;
      end
      S_P_A2: begin
        sum = t_r + alu_y;
        if (sum == '0) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_P_SEG;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_SQRT;
          alu_req.a     = sum;
          ret_nxt       = S_P_LEN;
          state_nxt     = S_WAIT;
        end
      end
      S_P_LEN: begin
        len_nxt       = alu_y;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = fx_r;
        alu_req.b     = dx_r;
        ret_nxt       = S_P_AL1;
        state_nxt     = S_WAIT;
      end
      S_P_AL1: begin
        t_nxt         = alu_y;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = fy_r;
        alu_req.b     = dy_r;
        ret_nxt       = S_P_AL2;
        state_nxt     = S_WAIT;
      end
      S_P_AL2: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.a     = t_r + alu_y;
        alu_req.b     = len_r;
        ret_nxt       = S_P_AL3;
        state_nxt     = S_WAIT;
      end
      S_P_AL3: begin
        along_nxt     = alu_y;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = dx_r;
        alu_req.b     = fy_r;
        ret_nxt       = S_P_CR1;
        state_nxt     = S_WAIT;
      end
      S_P_CR1: begin
        t_nxt         = alu_y;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = dy_r;
        alu_req.b     = fx_r;
        ret_nxt       = S_P_CR2;
        state_nxt     = S_WAIT;
      end
      S_P_CR2: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.a     = t_r - alu_y;
        alu_req.b     = len_r;
        ret_nxt       = S_P_CR3;
        state_nxt     = S_WAIT;
      end
      S_P_CR3: begin
        cr_nxt = alu_y;
        if (abs64(alu_y) > 64'(lk)) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_P_SEG;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_MUL;
          alu_req.a     = lk;
          alu_req.b     = lk;
          ret_nxt       = S_P_H1;
          state_nxt     = S_WAIT;
        end
      end
      S_P_H1: begin
        t_nxt         = alu_y;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = cr_r;
        alu_req.b     = cr_r;
        ret_nxt       = S_P_H2;
        state_nxt     = S_WAIT;
      end
      S_P_H2: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_SQRT;
        alu_req.a     = t_r - alu_y;
        ret_nxt       = S_P_HALF;
        state_nxt     = S_WAIT;
      end
      S_P_HALF: begin
        u0_nxt    = -along_r - alu_y;
        u1_nxt    = -along_r + alu_y;
        state_nxt = S_P_U;
      end
      S_P_U: begin
        if (!u0_r[63] && (u0_r <= len_r)) begin
          u_nxt         = u0_r;
          alu_req.start = 1'b1;
          alu_req.op    = OP_MUL;
          alu_req.a     = dx_r;
          alu_req.b     = u0_r;
          ret_nxt       = S_P_TX1;
          state_nxt     = S_WAIT;
        end else if (!u1_r[63] && (u1_r <= len_r)) begin
          u_nxt         = u1_r;
          alu_req.start = 1'b1;
          alu_req.op    = OP_MUL;
          alu_req.a     = dx_r;
          alu_req.b     = u1_r;
          ret_nxt       = S_P_TX1;
          state_nxt     = S_WAIT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_P_SEG;
        end
      end
      S_P_TX1: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.a     = alu_y;
        alu_req.b     = len_r;
        ret_nxt       = S_P_TX2;
        state_nxt     = S_WAIT;
      end
      S_P_TX2: begin
        tx_nxt        = fx_r + alu_y;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = dy_r;
        alu_req.b     = u_r;
        ret_nxt       = S_P_TY1;
        state_nxt     = S_WAIT;
      end
      S_P_TY1: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.a     = alu_y;
        alu_req.b     = len_r;
        ret_nxt       = S_P_TY2;
        state_nxt     = S_WAIT;
      end
      S_P_TY2: begin
        ty_nxt    = fy_r + alu_y;
        track_nxt = idx_r[ADDR_W-1:0];
        hit_nxt   = 1'b1;
        state_nxt = S_G_DIST;
      end

      // nearest point fallback, ties keep the lower index
      S_N_RD0: begin
        mem_raddr = track_r;
        state_nxt = S_N_MAG0;
      end
      S_N_MAG0: begin
        mx_nxt      = gx;
        my_nxt      = gy;
        best_nxt    = track_r;
        idx_nxt     = {1'b0, track_r} + 1'b1;
        mag_ret_nxt = S_N_BEST;
        state_nxt   = S_MAG0;
      end
      S_N_BEST: begin
        bd_nxt    = mag_r;
        state_nxt = S_N_RD;
      end
      S_N_RD: begin
        if (idx_r >= count_r) begin
          state_nxt = S_N_TGT_RD;
        end else begin
          mem_raddr = idx_r[ADDR_W-1:0];
          state_nxt = S_N_MAG;
        end
      end
      S_N_MAG: begin
        mx_nxt      = gx;
        my_nxt      = gy;
        mag_ret_nxt = S_N_CMP;
        state_nxt   = S_MAG0;
      end
      S_N_CMP: begin
        if (mag_r < bd_r) begin
          bd_nxt   = mag_r;
          best_nxt = idx_r[ADDR_W-1:0];
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_N_RD;
      end
      S_N_TGT_RD: begin
        track_nxt = best_r;
        mem_raddr = best_r;
        state_nxt = S_N_TGT;
      end
      S_N_TGT: begin
        tx_nxt    = gx;
        ty_nxt    = gy;
        state_nxt = S_G_DIST;
      end

      // goal check, car frame transform and steering
      S_G_DIST: begin
        mx_nxt      = sx32(px_r) - sx32(goal_x_r);
        my_nxt      = sx32(py_r) - sx32(goal_y_r);
        mag_ret_nxt = S_G_CHK;
        state_nxt   = S_MAG0;
      end
      S_G_CHK: begin
        gd_nxt = mag_r;
        if (mag_r <= $signed({43'd0, cfg.goal_radius})) begin
          track_nxt     = '0;
          armed_nxt     = 1'b0;
          res_steer_nxt = '0;
          res_speed_nxt = '0;
          res_goal_nxt  = 1'b1;
          res_held_nxt  = 1'b0;
          res_near_nxt  = 1'b0;
          state_nxt     = S_OUT;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_MUL;
          alu_req.a     = sx16(hc_r);
          alu_req.b     = tx_r;
          ret_nxt       = S_G_X1;
          state_nxt     = S_WAIT;
        end
      end
      S_G_X1: begin
        t_nxt         = alu_y;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = sx16(hs_r);
        alu_req.b     = ty_r;
        ret_nxt       = S_G_X2;
        state_nxt     = S_WAIT;
      end
      S_G_X2: begin
        xc_nxt        = (t_r + alu_y + RND14) >>> 14;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = sx16(hc_r);
        alu_req.b     = ty_r;
        ret_nxt       = S_G_Y1;
        state_nxt     = S_WAIT;
      end
      S_G_Y1: begin
        t_nxt         = alu_y;
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = sx16(hs_r);
        alu_req.b     = tx_r;
        ret_nxt       = S_G_Y2;
        state_nxt     = S_WAIT;
      end
      S_G_Y2: begin
        sum         = (t_r - alu_y + RND14) >>> 14;
        yc_nxt      = sum;
        mx_nxt      = xc_r;
        my_nxt      = sum;
        mag_ret_nxt = S_G_D;
        state_nxt   = S_MAG0;
      end
      S_G_D: begin
        d_nxt = mag_r;
        if (mag_r == '0) begin
          t_nxt     = '0;
          state_nxt = S_G_S;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_DIV;
          alu_req.a     = yc_r <<< 16;
          alu_req.b     = mag_r;
          ret_nxt       = S_G_R;
          state_nxt     = S_WAIT;
        end
      end
      S_G_R: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.a     = alu_y <<< 17;
        alu_req.b     = d_r;
        ret_nxt       = S_G_ST;
        state_nxt     = S_WAIT;
      end
      S_G_ST: begin
        t_nxt     = alu_y;
        state_nxt = S_G_S;
      end
      S_G_S: begin
        if (t_r > lim) begin
          steer         = lim;
          res_speed_nxt = cfg.slow_speed;
        end else if (t_r < -lim) begin
          steer         = -lim;
          res_speed_nxt = cfg.slow_speed;
        end else if (gd_r <= NEAR_GOAL) begin
          res_speed_nxt = cfg.slow_speed;
        end else if ($signed(abs64(t_r)) >= STEER_MID) begin
          res_speed_nxt = cfg.mid_speed;
        end else begin
          res_speed_nxt = cfg.top_speed;
        end
        res_steer_nxt  = steer[17:0];
        held_steer_nxt = steer[17:0];
        held_speed_nxt = res_speed_nxt;
        res_goal_nxt   = 1'b0;
        res_held_nxt   = 1'b0;
        res_near_nxt   = !hit_r;
        state_nxt      = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_steer_nxt = res_steer_r;
          out_speed_nxt = res_speed_r;
          out_goal_nxt  = res_goal_r;
          out_held_nxt  = res_held_r;
          out_near_nxt  = res_near_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_steering     = out_steer_r;
  assign out_speed        = out_speed_r;
  assign out_goal_reached = out_goal_r;
  assign out_held         = out_held_r;
  assign out_used_nearest = out_near_r;

endmodule
`default_nettype wire

// File: hw/rtl/pure_pursuit_path_tracker_core.sv
// input words are taken one word at a time: in_stall stays high until the result of the
//   last word is registered at the output, and a stalled output holds it there; all
//   arithmetic runs through one bit-serial mul/div/sqrt unit
// reset: path store contents undefined, no path armed, registers at defaults
`default_nettype none
module pure_pursuit_path_tracker_core import ppt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_func,
  input  wire logic signed [31:0]    in_pos_x,
  input  wire logic signed [31:0]    in_pos_y,
  input  wire logic signed [15:0]    in_heading_cos,
  input  wire logic signed [15:0]    in_heading_sin,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [17:0]         out_steering,
  output logic [21:0]                out_speed,
  output logic                       out_goal_reached,
  output logic                       out_held,
  output logic                       out_used_nearest,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lookahead     <= LOOKAHEAD_RST;
      cfg_r.goal_radius   <= GOAL_RADIUS_RST;
      cfg_r.steer_limit   <= STEER_LIMIT_RST;
      cfg_r.point_spacing <= POINT_SPACING_RST;
      cfg_r.hold_count    <= HOLD_COUNT_RST;
      cfg_r.slow_speed    <= SLOW_SPEED_RST;
      cfg_r.mid_speed     <= MID_SPEED_RST;
      cfg_r.top_speed     <= TOP_SPEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_LOOKAHEAD:     cfg_nxt.lookahead     = cfg_data[20:0];
        CFG_GOAL_RADIUS:   cfg_nxt.goal_radius   = cfg_data[20:0];
        CFG_STEER_LIMIT:   cfg_nxt.steer_limit   = cfg_data[16:0];
        CFG_POINT_SPACING: cfg_nxt.point_spacing = cfg_data[20:0];
        CFG_HOLD_COUNT:    cfg_nxt.hold_count    = cfg_data[7:0];
        CFG_SLOW_SPEED:    cfg_nxt.slow_speed    = cfg_data;
        CFG_MID_SPEED:     cfg_nxt.mid_speed     = cfg_data;
        CFG_TOP_SPEED:     cfg_nxt.top_speed     = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  ppt_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  ppt_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_heading_cos   (in_heading_cos),
    .in_heading_sin   (in_heading_sin),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_steering     (out_steering),
    .out_speed        (out_speed),
    .out_goal_reached (out_goal_reached),
    .out_held         (out_held),
    .out_used_nearest (out_used_nearest),
    .alu_req          (alu_req),
    .alu_rsp          (alu_rsp)
  );

endmodule
`default_nettype wire
